/* hdl/mdh_pkg.sv */
package mdh_pkg;

    // Character codes used by the line parser
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_TICK   = 8'h60;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_BRACK  = 8'h5B;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [2:0] MAX_LEVEL = 3'd6;

    // Tag text, right-aligned: leftmost character in the highest used byte
    localparam logic [8*9-1:0] STR_EM_OPEN      = 72'("<em>");
    localparam logic [8*9-1:0] STR_EM_CLOSE     = 72'("</em>");
    localparam logic [8*9-1:0] STR_STRONG_OPEN  = 72'("<strong>");
    localparam logic [8*9-1:0] STR_STRONG_CLOSE = 72'("</strong>");

    // Leading tag of a burst
    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_EM_OPEN,
        TAG_EM_CLOSE,
        TAG_STRONG_OPEN,
        TAG_STRONG_CLOSE,
        TAG_H_OPEN
    } tag_t;

    // Trailing part of a burst
    typedef enum logic [1:0] {
        SUF_NONE,
        SUF_CHAR,
        SUF_NL,
        SUF_H_CLOSE
    } suf_t;

    // One burst of HTML bytes caused by a single input transfer
    typedef struct packed {
        tag_t       tag;
        suf_t       suf;
        logic [2:0] level;
        logic [7:0] ch;
    } burst_t;

    function automatic logic [7:0] str_pick(logic [8*9-1:0] s, logic [3:0] len,
                                            logic [3:0] i);
        logic [3:0] pos;
        pos = len - 4'd1 - i;
        return s[{pos, 3'b000} +: 8];
    endfunction

    function automatic logic [3:0] tag_len(tag_t tag);
        case (tag)
            TAG_EM_OPEN:      return 4'd4;
            TAG_EM_CLOSE:     return 4'd5;
            TAG_STRONG_OPEN:  return 4'd8;
            TAG_STRONG_CLOSE: return 4'd9;
            TAG_H_OPEN:       return 4'd4;
            default:          return 4'd0;
        endcase
    endfunction

    function automatic logic [3:0] suf_len(suf_t suf);
        case (suf)
            SUF_CHAR:    return 4'd1;
            SUF_NL:      return 4'd1;
            SUF_H_CLOSE: return 4'd6;
            default:     return 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] tag_byte(tag_t tag, logic [2:0] level, logic [3:0] i);
        logic [8*9-1:0] h_open;
        h_open = {40'd0, "<h", CH_ZERO + {5'd0, level}, ">"};
        case (tag)
            TAG_EM_OPEN:      return str_pick(STR_EM_OPEN, 4'd4, i);
            TAG_EM_CLOSE:     return str_pick(STR_EM_CLOSE, 4'd5, i);
            TAG_STRONG_OPEN:  return str_pick(STR_STRONG_OPEN, 4'd8, i);
            TAG_STRONG_CLOSE: return str_pick(STR_STRONG_CLOSE, 4'd9, i);
            TAG_H_OPEN:       return str_pick(h_open, 4'd4, i);
            default:          return CH_NUL;
        endcase
    endfunction

    function automatic logic [7:0] suf_byte(suf_t suf, logic [2:0] level, logic [7:0] ch,
                                            logic [3:0] i);
        logic [8*9-1:0] h_close;
        h_close = {24'd0, "</h", CH_ZERO + {5'd0, level}, ">", CH_NL};
        case (suf)
            SUF_CHAR:    return ch;
            SUF_NL:      return CH_NL;
            SUF_H_CLOSE: return str_pick(h_close, 4'd6, i);
            default:     return CH_NUL;
        endcase
    endfunction

endpackage

/* hdl/markdown_subset_to_html.sv */
// The first HTML byte of an input transfer is valid in the cycle after the transfer.
// Throughput: one input transfer per cycle while each causes at most one byte and
//   the output does not stall; a transfer causing more bytes (up to 10) holds off the
//   next transfer until its last byte leaves the single-byte output burst register.
// Reset: rst_n is asynchronous, active low; it returns the parser to line start
//   with emphasis cleared and empties the output burst.
module markdown_subset_to_html
    import mdh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] html_byte,
    output logic       last_of_run
);

    logic   take;
    logic   has_output;
    burst_t burst;

    assign take = in_valid && in_ready;

    // Parse the input byte against the line state
    mdh_parse u_parse
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .burst       (burst),
        .has_output  (has_output)
    );

    // Serialize the resulting burst onto the output channel
    mdh_burst u_burst
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take && has_output),
        .burst_in    (burst),
        .free        (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .html_byte   (html_byte),
        .last_of_run (last_of_run)
    );

endmodule

/* hdl/mdh_parse.sv */
module mdh_parse
    import mdh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output burst_t     burst,
    output logic       has_output
);

    typedef enum logic [2:0] {
        MODE_START,
        MODE_HASH,
        MODE_HEAD,
        MODE_PARA,
        MODE_DROP
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [2:0] hash_count_reg, hash_count_next;
    logic       bold_open_reg, bold_open_next;
    logic       italic_open_reg, italic_open_next;
    logic       star_pending_reg, star_pending_next;

    logic [7:0] c;
    logic       is_end;
    logic       is_drop_char;
    logic       do_para;
    tag_t       tag;
    suf_t       suf;

    // Classify the byte against the line state and build the burst
    always_comb
    begin
        c            = end_of_text ? CH_NL : text_byte;
        is_end       = (c == CH_NL) || (c == CH_NUL);
        is_drop_char = (c == CH_TICK) || (c == CH_DASH) || (c == CH_BRACK) ||
                       (c == CH_BANG) || (c == CH_GT);

        mode_next         = mode_reg;
        hash_count_next   = hash_count_reg;
        bold_open_next    = bold_open_reg;
        italic_open_next  = italic_open_reg;
        star_pending_next = star_pending_reg;
        tag               = TAG_NONE;
        suf               = SUF_NONE;
        do_para           = 1'b0;

        case (mode_reg)
            MODE_START:
            begin
                if (c == CH_NL)
                begin
                    mode_next = MODE_START;
                end
                else if (c == CH_NUL || is_drop_char)
                begin
                    mode_next = MODE_DROP;
                end
                else if (c == CH_HASH)
                begin
                    mode_next       = MODE_HASH;
                    hash_count_next = 3'd1;
                end
                else
                begin
                    mode_next = MODE_PARA;
                    do_para   = 1'b1;
                end
            end
            MODE_HASH:
            begin
                if (c == CH_HASH)
                begin
                    if (hash_count_reg >= MAX_LEVEL)
                    begin
                        mode_next       = MODE_DROP;
                        hash_count_next = 3'd0;
                    end
                    else
                    begin
                        hash_count_next = hash_count_reg + 3'd1;
                    end
                end
                else
                begin
                    // The byte after the hashes is skipped
                    tag = TAG_H_OPEN;
                    if (is_end)
                    begin
                        suf             = SUF_H_CLOSE;
                        mode_next       = (c == CH_NL) ? MODE_START : MODE_DROP;
                        hash_count_next = 3'd0;
                    end
                    else
                    begin
                        mode_next = MODE_HEAD;
                    end
                end
            end
            MODE_HEAD:
            begin
                if (is_end)
                begin
                    suf             = SUF_H_CLOSE;
                    mode_next       = (c == CH_NL) ? MODE_START : MODE_DROP;
                    hash_count_next = 3'd0;
                end
                else
                begin
                    suf = SUF_CHAR;
                end
            end
            MODE_PARA:
            begin
                do_para = 1'b1;
            end
            default:
            begin
                if (c == CH_NL)
                begin
                    mode_next = MODE_START;
                end
            end
        endcase

        // Paragraph text: stars toggle emphasis, line end closes the line
        if (do_para)
        begin
            if (c == CH_STAR)
            begin
                if (star_pending_reg)
                begin
                    star_pending_next = 1'b0;
                    tag               = bold_open_reg ? TAG_STRONG_CLOSE : TAG_STRONG_OPEN;
                    bold_open_next    = !bold_open_reg;
                end
                else
                begin
                    star_pending_next = 1'b1;
                end
            end
            else
            begin
                if (star_pending_reg)
                begin
                    star_pending_next = 1'b0;
                    tag               = italic_open_reg ? TAG_EM_CLOSE : TAG_EM_OPEN;
                    italic_open_next  = !italic_open_reg;
                end
                if (is_end)
                begin
                    suf               = SUF_NL;
                    mode_next         = (c == CH_NL) ? MODE_START : MODE_DROP;
                    bold_open_next    = 1'b0;
                    italic_open_next  = 1'b0;
                    star_pending_next = 1'b0;
                end
                else
                begin
                    suf = SUF_CHAR;
                end
            end
        end
    end

    assign burst.tag   = tag;
    assign burst.suf   = suf;
    assign burst.level = hash_count_reg;
    assign burst.ch    = c;
    assign has_output  = (tag != TAG_NONE) || (suf != SUF_NONE);

    // Advance line state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_START;
            hash_count_reg   <= 3'd0;
            bold_open_reg    <= 1'b0;
            italic_open_reg  <= 1'b0;
            star_pending_reg <= 1'b0;
        end
        else if (take)
        begin
            mode_reg         <= mode_next;
            hash_count_reg   <= hash_count_next;
            bold_open_reg    <= bold_open_next;
            italic_open_reg  <= italic_open_next;
            star_pending_reg <= star_pending_next;
        end
    end

endmodule

/* hdl/mdh_burst.sv */
module mdh_burst
    import mdh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  burst_t     burst_in,
    output logic       free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] html_byte,
    output logic       last_of_run
);

    logic       valid_reg, valid_next;
    burst_t     burst_reg;
    logic [3:0] idx_reg, idx_next;
    logic [3:0] tlen;
    logic [3:0] total;
    logic       is_last;
    logic       out_xfer;

    // Pick the current byte from the tag or the trailing part
    always_comb
    begin
        tlen    = tag_len(burst_reg.tag);
        total   = tlen + suf_len(burst_reg.suf);
        is_last = (idx_reg == total - 4'd1);
        if (idx_reg < tlen)
        begin
            html_byte = tag_byte(burst_reg.tag, burst_reg.level, idx_reg);
        end
        else
        begin
            html_byte = suf_byte(burst_reg.suf, burst_reg.level, burst_reg.ch,
                                 idx_reg - tlen);
        end
    end

    assign out_valid   = valid_reg;
    assign last_of_run = is_last;
    assign out_xfer    = valid_reg && out_ready;
    assign free        = !valid_reg || (out_ready && is_last);

    // Step through the burst, reload when the last byte leaves or the register is empty
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (out_xfer)
        begin
            if (is_last)
            begin
                valid_next = 1'b0;
                idx_next   = 4'd0;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Hold the burst payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst_in;
        end
    end

endmodule

/* hdl/mdh_checker.sv */
module mdh_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] html_byte,
    input logic       last_of_run
);

    // Stalled output holds its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(html_byte) && $stable(last_of_run))
    else $error("output changed while stalled");

    // With nothing pending the input is open
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input blocked with empty output");

    // A burst continues after a non-final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("burst ended without final byte");

    // No new input while a burst is still mid-way
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !in_ready)
    else $error("input taken during a burst");

endmodule

bind markdown_subset_to_html mdh_checker u_mdh_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .html_byte   (html_byte),
    .last_of_run (last_of_run)
);
